>>> hw/rtl/sbfd_pkg.sv
// Shared constants, types and helpers of the serial-bus frame decoder.
// No dependencies; imported by every module of the block.
package sbfd_pkg;

  localparam int unsigned FRAME_BYTES       = 25;
  localparam int unsigned NUM_CHANNELS_DEF  = 18;
  localparam int unsigned ANALOG_CHANNELS   = 16;
  localparam int unsigned RAW_W             = 11;
  localparam int unsigned CHAN_IDX_W        = 5;
  localparam int unsigned VALUE_W           = 16;
  localparam int unsigned LIMIT_W           = 12;
  localparam int unsigned CHAN_BITS_W       = ANALOG_CHANNELS * RAW_W;
  localparam int unsigned FLAG_W            = 4;
  localparam int unsigned IN_DATA_W         = 8;
  localparam int unsigned OUT_DATA_W        = 40;

  localparam logic [LIMIT_W-1:0] BURST_LIMIT_RESET = 12'd50;
  localparam logic [LIMIT_W-1:0] MATCH_COUNT_MIN   = LIMIT_W'(FRAME_BYTES);
  localparam logic [LIMIT_W-1:0] STALL_COUNT_MIN   = LIMIT_W'(FRAME_BYTES - 1);

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FOOTER_A    = 8'h00;
  localparam logic [7:0] FOOTER_B    = 8'h04;
  localparam logic [7:0] FOOTER_C    = 8'h14;
  localparam logic [7:0] FOOTER_D    = 8'h24;
  localparam logic [7:0] FOOTER_E    = 8'h34;

  localparam logic [RAW_W:0]     NORM_OFFSET = 12'd172;
  localparam int unsigned        NORM_X_W    = 25;
  localparam int unsigned        NORM_SHIFT  = 36;
  localparam int unsigned        NORM_K_W    = 26;
  localparam logic [NORM_X_W-1:0] NORM_ROUND = 25'd819;
  localparam logic [NORM_K_W-1:0] NORM_RECIP =
    NORM_K_W'(((64'd1 << NORM_SHIFT) + 64'd1638) / 64'd1639);
  localparam logic [VALUE_W-1:0] DIGITAL_ONE = 16'd16384;

  typedef struct packed {
    logic                   load;
    logic [CHAN_BITS_W-1:0] chan_bits;
    logic [FLAG_W-1:0]      flags;
  } frame_t;

  typedef struct packed {
    logic busy;
  } emit_status_t;

  function automatic logic footer_ok(input logic [7:0] b);
    logic ok;
    case (b) inside
      FOOTER_A, FOOTER_B, FOOTER_C, FOOTER_D, FOOTER_E: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> hw/rtl/sbus_frame_decoder_top.sv
// Top level of the serial-bus frame decoder: frame finder and channel unpacker.
// Depends on sbfd_pkg, sbfd_frame_finder and sbfd_channel_unpack.
//
// Usage:
//   Slave stream carries one received byte per transfer in s_axis_tdata; a
//   high s_axis_tuser marks the first byte of a new burst. Once a 25-byte
//   window with a valid header and footer is seen within a burst, the frame
//   is captured and the rest of the burst is dropped.
//   Master stream emits one transfer per channel: analog channels 0..15,
//   then the digital channels, with m_axis_tlast on the final one.
//   cfg_we_i writes the burst limit; write only while the block is idle.
//   Throughput: one byte per cycle while s_axis_tready is high. A frame drains
//   at one channel per cycle unless the receiver stalls; the match loads the
//   frame registers, which feed the output register, where results hold on a
//   stall while bytes keep flowing; s_axis_tready drops only when a further
//   match could occur before the unpacker has released the previous frame.
//   Reset clears the window to zeros, the burst count and the match flag,
//   and loads a burst limit of 50; the block then acts as at a burst start.
module sbus_frame_decoder_top #(
  parameter int unsigned NUM_CHANNELS = sbfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbfd_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] data_byte
  input  logic [sbfd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] burst_start
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [4:0] channel_index, [15:5] raw_value, [31:16] channel_value,
  // [32] frame_lost, [33] failsafe, [34] signal_ok, [39:35] zero
  output logic [sbfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import sbfd_pkg::*;

  frame_t       frame;
  emit_status_t emit;

  sbfd_frame_finder u_finder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser),
    .emit_i      (emit),
    .frame_o     (frame)
  );

  sbfd_channel_unpack #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame),
    .emit_o      (emit),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> hw/rtl/sbfd_frame_finder.sv
// Byte window, burst counting and frame match; presents a matched frame for capture.
// Depends on sbfd_pkg.
module sbfd_frame_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbfd_pkg::LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sbfd_pkg::IN_DATA_W-1:0]  in_byte_i,
  input  logic                            in_start_i,
  input  sbfd_pkg::emit_status_t          emit_i,
  output sbfd_pkg::frame_t                frame_o
);
  import sbfd_pkg::*;

  logic [7:0]         window_q [FRAME_BYTES-1];
  logic [LIMIT_W-1:0] count_q, count_d, count_eff;
  logic [LIMIT_W-1:0] limit_q;
  logic               found_q, found_d, found_eff;
  logic               accept, ignore, match;

  assign in_ready_o = !(emit_i.busy && !found_q && (count_q >= STALL_COUNT_MIN));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    count_eff = in_start_i ? '0 : count_q;
    found_eff = in_start_i ? 1'b0 : found_q;
    ignore    = found_eff || (count_eff >= limit_q);
    count_d   = ignore ? count_eff : count_eff + 1'b1;
    match     = !ignore && (count_d >= MATCH_COUNT_MIN) &&
                (window_q[0] == HEADER_BYTE) && footer_ok(in_byte_i);
    found_d   = found_eff || match;
  end

  always_comb begin
    frame_o.load  = accept && match;
    frame_o.flags = window_q[FRAME_BYTES-2][FLAG_W-1:0];
    for (int k = 0; k < CHAN_BITS_W / 8; k++) begin
      frame_o.chan_bits[k*8 +: 8] = window_q[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      found_q <= 1'b0;
      limit_q <= BURST_LIMIT_RESET;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
        found_q <= found_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRAME_BYTES - 1; k++) begin
        window_q[k] <= '0;
      end
    end else if (accept && !ignore) begin
      for (int k = 0; k < FRAME_BYTES - 2; k++) begin
        window_q[k] <= window_q[k+1];
      end
      window_q[FRAME_BYTES-2] <= in_byte_i;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.load |-> !emit_i.busy)
    else $error("frame captured while previous frame still unpacking");

  a_found_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.load |=> found_q)
    else $error("match not recorded after frame capture");

endmodule

>>> hw/rtl/sbfd_channel_unpack.sv
// Holds a captured frame and emits one normalised channel per transfer.
// Depends on sbfd_pkg.
module sbfd_channel_unpack #(
  parameter int unsigned NUM_CHANNELS = sbfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbfd_pkg::frame_t                 frame_i,
  output sbfd_pkg::emit_status_t           emit_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sbfd_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic                             out_last_o
);
  import sbfd_pkg::*;

  localparam logic [CHAN_IDX_W-1:0] LAST_CH = CHAN_IDX_W'(NUM_CHANNELS - 1);
  localparam logic [CHAN_IDX_W-1:0] DIG_CH0 = CHAN_IDX_W'(ANALOG_CHANNELS);

  logic [CHAN_BITS_W-1:0] bits_q;
  logic [FLAG_W-1:0]      flags_q;
  logic                   busy_q;
  logic [CHAN_IDX_W-1:0]  ch_q;
  logic                   advance;

  logic [RAW_W-1:0]       raw;
  logic [RAW_W:0]         diff;
  logic                   neg;
  logic [RAW_W-1:0]       mag;
  logic [NORM_X_W-1:0]    x;
  logic [NORM_X_W+NORM_K_W-1:0] prod;
  logic [VALUE_W-1:0]     quot, value;
  logic                   lost, fs, ok;

  logic                   valid_q;
  logic [CHAN_IDX_W-1:0]  idx_q;
  logic [RAW_W-1:0]       raw_q;
  logic [VALUE_W-1:0]     value_q;
  logic                   lost_q, fs_q, ok_q, last_q;

  assign advance     = busy_q && (!valid_q || out_ready_i);
  assign emit_o.busy = busy_q;

  always_comb begin
    diff = {1'b0, bits_q[ch_q[3:0]*RAW_W +: RAW_W]} - NORM_OFFSET;
    neg  = diff[RAW_W];
    mag  = neg ? RAW_W'(-diff) : diff[RAW_W-1:0];
    x    = {mag, 14'b0} + NORM_ROUND;
    prod = x * NORM_RECIP;
    quot = {1'b0, prod[NORM_SHIFT +: VALUE_W-1]};
    if (ch_q >= DIG_CH0) begin
      raw   = {{(RAW_W-1){1'b0}}, flags_q[ch_q[0]]};
      value = flags_q[ch_q[0]] ? '0 : DIGITAL_ONE;
    end else begin
      raw   = bits_q[ch_q[3:0]*RAW_W +: RAW_W];
      value = neg ? -quot : quot;
    end
    lost = flags_q[2];
    fs   = flags_q[3];
    ok   = !(lost || fs);
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.load) begin
      bits_q  <= frame_i.chan_bits;
      flags_q <= frame_i.flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ch_q   <= '0;
    end else if (frame_i.load) begin
      busy_q <= 1'b1;
      ch_q   <= '0;
    end else if (advance) begin
      if (ch_q == LAST_CH) begin
        busy_q <= 1'b0;
      end else begin
        ch_q <= ch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      idx_q   <= ch_q;
      raw_q   <= raw;
      value_q <= value;
      lost_q  <= lost;
      fs_q    <= fs;
      ok_q    <= ok;
      last_q  <= (ch_q == LAST_CH);
    end
  end

  assign out_valid_o = valid_q;
  assign out_last_o  = last_q;
  assign out_data_o  = {5'b0, ok_q, fs_q, lost_q, value_q, raw_q, idx_q};

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ch_q == LAST_CH) |=> !busy_q)
    else $error("unpacker still busy after final channel");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q <= LAST_CH) && (last_q == (idx_q == LAST_CH)))
    else $error("channel index or last flag out of step");

endmodule

>>> tb/sbus_frame_decoder_top_tb.sv
// Self-checking testbench for sbus_frame_decoder_top: byte stream in, channel results out.
// Predicts every channel from its own copy of the window, burst count and limit.
// Depends on sbfd_pkg and the RTL of sbus_frame_decoder_top.
module sbus_frame_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbfd_pkg::*;

  localparam int unsigned NCH         = NUM_CHANNELS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CHAN_IDX_W-1:0] idx;
    logic [RAW_W-1:0]      raw;
    logic [VALUE_W-1:0]    val;
    logic                  lost;
    logic                  fs;
    logic                  ok;
    logic                  last;
  } chan_result_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  sbus_frame_decoder_top #(.NUM_CHANNELS(NCH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // decoder state as predicted
  logic [191:0]     byte_hist  = '0;
  int unsigned      burst_len  = 0;
  logic             frame_seen = 1'b0;
  int unsigned      limit_reg  = BURST_LIMIT_RESET;
  chan_result_t     expected_channels[$];

  int unsigned errors      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned chans_seen  = 0;
  int unsigned frames_seen = 0;
  int unsigned cycle_count = 0;
  bit          src_gaps    = 1'b1;
  bit          sink_gaps   = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic is_footer(input logic [7:0] b);
    return b == FOOTER_A || b == FOOTER_B || b == FOOTER_C || b == FOOTER_D || b == FOOTER_E;
  endfunction

  function automatic logic [VALUE_W-1:0] norm_q214(input int raw);
    int num;
    num = (raw - 172) * 16384;
    if (num >= 0) begin
      return VALUE_W'((num + 819) / 1639);
    end
    return VALUE_W'(-((-num + 819) / 1639));
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic mark);
    logic [199:0] win;
    logic [175:0] bits;
    logic [7:0]   flags;
    chan_result_t r;
    if (mark) begin
      burst_len  = 0;
      frame_seen = 1'b0;
    end
    if (frame_seen || burst_len >= limit_reg) return;
    burst_len++;
    win       = {b, byte_hist};
    byte_hist = win[199:8];
    if (burst_len < FRAME_BYTES) return;
    if (win[7:0] != HEADER_BYTE || !is_footer(win[199:192])) return;
    frame_seen = 1'b1;
    flags = win[191:184];
    bits  = win[183:8];
    for (int i = 0; i < NCH; i++) begin
      r.idx = CHAN_IDX_W'(i);
      if (i < ANALOG_CHANNELS) begin
        r.raw = bits[i*RAW_W +: RAW_W];
        r.val = norm_q214(int'(r.raw));
      end else begin
        r.raw = RAW_W'(flags[i-ANALOG_CHANNELS]);
        r.val = flags[i-ANALOG_CHANNELS] ? '0 : DIGITAL_ONE;
      end
      r.lost = flags[2];
      r.fs   = flags[3];
      r.ok   = !(flags[2] | flags[3]);
      r.last = (i == NCH - 1);
      expected_channels.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    errors++;
    $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    chan_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chans_seen++;
      if (m_axis_tlast) frames_seen++;
      if (expected_channels.size() == 0) begin
        report_mismatch("unexpected transfer, channel", -1, m_axis_tdata[4:0]);
      end else begin
        want = expected_channels.pop_front();
        if (m_axis_tdata[4:0] != want.idx)
          report_mismatch("channel_index", want.idx, m_axis_tdata[4:0]);
        if (m_axis_tdata[15:5] != want.raw)
          report_mismatch("raw_value", want.raw, m_axis_tdata[15:5]);
        if (m_axis_tdata[31:16] != want.val)
          report_mismatch("channel_value", $signed(want.val), $signed(m_axis_tdata[31:16]));
        if (m_axis_tdata[32] != want.lost)
          report_mismatch("frame_lost", want.lost, m_axis_tdata[32]);
        if (m_axis_tdata[33] != want.fs)
          report_mismatch("failsafe", want.fs, m_axis_tdata[33]);
        if (m_axis_tdata[34] != want.ok)
          report_mismatch("signal_ok", want.ok, m_axis_tdata[34]);
        if (m_axis_tdata[39:35] != '0)
          report_mismatch("padding", 0, m_axis_tdata[39:35]);
        if (m_axis_tlast != want.last)
          report_mismatch("tlast", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver side: random stalls, always ready once idling is switched off
  initial begin
    @(posedge rst_ni);
    forever begin
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic mark);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= mark;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, mark);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [199:0] fr, input logic mark);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      send_byte(fr[8*k +: 8], mark && k == 0);
    end
  endtask

  task automatic write_limit(input int unsigned value);
    s_axis_tvalid <= 1'b0;
    while (expected_channels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LIMIT_W'(value);
    @(posedge clk_i);
    limit_reg = value & 12'hFFF;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [175:0] rand_channels();
    logic [175:0] bits;
    for (int i = 0; i < ANALOG_CHANNELS; i++) begin
      case ($urandom_range(0, 5))
        0:       bits[i*RAW_W +: RAW_W] = '0;
        1:       bits[i*RAW_W +: RAW_W] = '1;
        2:       bits[i*RAW_W +: RAW_W] = RAW_W'(172);
        default: bits[i*RAW_W +: RAW_W] = RAW_W'($urandom_range(0, 2047));
      endcase
    end
    return bits;
  endfunction

  // frame straight after reset with no burst mark, then bytes after the match
  task automatic test_frame_after_reset();
    logic [175:0] bits;
    for (int i = 0; i < ANALOG_CHANNELS; i++) begin
      bits[i*RAW_W +: RAW_W] = (i % 2) ? '1 : '0;
    end
    send_frame({FOOTER_A, 8'h03, bits, HEADER_BYTE}, 1'b0);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(FOOTER_A, 1'b0);
  endtask

  // valid frame split over two bursts: the straddling window must not match
  task automatic test_split_burst();
    logic [199:0] fr;
    logic [175:0] bits;
    for (int i = 0; i < ANALOG_CHANNELS; i++) begin
      bits[i*RAW_W +: RAW_W] = RAW_W'(172);
    end
    fr = {FOOTER_B, 8'hF0, bits, HEADER_BYTE};
    for (int k = 0; k < FRAME_BYTES; k++) begin
      send_byte(fr[8*k +: 8], k == 0 || k == 12);
    end
  endtask

  task automatic send_random_burst();
    logic [7:0]  footer;
    logic [7:0]  hdr;
    logic        mark;
    int unsigned pre;
    mark = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) begin
        send_byte(8'($urandom_range(0, 255)), mark);
        mark = 1'b0;
      end
      return;
    end
    pre = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
    repeat (pre) begin
      send_byte(8'($urandom_range(0, 255)), mark);
      mark = 1'b0;
    end
    case ($urandom_range(0, 5))
      0:       footer = FOOTER_A;
      1:       footer = FOOTER_B;
      2:       footer = FOOTER_C;
      3:       footer = FOOTER_D;
      4:       footer = FOOTER_E;
      default: footer = 8'($urandom_range(0, 255));
    endcase
    hdr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : HEADER_BYTE;
    send_frame({footer, 8'($urandom_range(0, 255)), rand_channels(), hdr}, mark);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic test_random_bursts(input int unsigned limit, input int unsigned n_bytes);
    int unsigned start;
    write_limit(limit);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_burst();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_frame_after_reset();
    test_split_burst();
    test_random_bursts(4095, 95);
    test_random_bursts(25, 95);
    test_random_bursts(24, 95);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_bursts($urandom_range(26, 60), 95);

    s_axis_tvalid <= 1'b0;
    while (expected_channels.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d bytes over limits 50, 4095, 25, 24 and a random one;", bytes_sent);
    $display("checked %0d channel results in %0d decoded frames.", chans_seen, frames_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
